FILE: rtl/pqr_pkg.sv
// Package: types, register codes and fixed-point helpers for the plane quaternion rotate unit.
package pqr_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned CsrIdWidth = 3;

   typedef enum logic [CsrIdWidth-1:0] {
      CSR_QUAT_X = 3'd0,
      CSR_QUAT_Y = 3'd1,
      CSR_QUAT_Z = 3'd2,
      CSR_QUAT_W = 3'd3
   } csr_index_type;

   localparam logic signed [DataWidth-1:0] QuatXReset = 32'sd0;
   localparam logic signed [DataWidth-1:0] QuatYReset = 32'sd0;
   localparam logic signed [DataWidth-1:0] QuatZReset = 32'sd0;
   localparam logic signed [DataWidth-1:0] QuatWReset = 32'sd1073741824;

   localparam logic signed [35:0] QOne   = 36'sd1073741824;
   localparam logic signed [35:0] SatMax = 36'sh07FFFFFFF;
   localparam logic signed [35:0] SatMin = 36'shF80000000;

   typedef struct packed {
      logic signed [DataWidth-1:0] normal_x;
      logic signed [DataWidth-1:0] normal_y;
      logic signed [DataWidth-1:0] normal_z;
      logic signed [DataWidth-1:0] offset_d;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] rotated_x;
      logic signed [DataWidth-1:0] rotated_y;
      logic signed [DataWidth-1:0] rotated_z;
      logic signed [DataWidth-1:0] offset_out;
   } rsp_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] x;
      logic signed [DataWidth-1:0] y;
      logic signed [DataWidth-1:0] z;
      logic signed [DataWidth-1:0] w;
   } quat_type;

   // row-major rotation matrix, entry r*3+c
   typedef logic [8:0][DataWidth-1:0] mat_type;

   // doubled product: (p + 2^28) >>> 29
   function automatic logic signed [34:0] rnd_dbl(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd268435456;
      return t[63:29];
   endfunction

   // row term: (p + 2^29) >>> 30
   function automatic logic signed [33:0] rnd_row(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912;
      return t[63:30];
   endfunction

   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [35:0] v);
      logic signed [DataWidth-1:0] r;
      if (v > SatMax) begin
         r = SatMax[DataWidth-1:0];
      end else if (v < SatMin) begin
         r = SatMin[DataWidth-1:0];
      end else begin
         r = v[DataWidth-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/pqr_csr.sv
// Quaternion configuration registers with plain write port.
module pqr_csr import pqr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CsrIdWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]  csr_wdata,
   output quat_type              quat
);

   quat_type quat_ff;
   quat_type quat_in;

   always_comb begin
      quat_in = quat_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUAT_X: quat_in.x = csr_wdata;
            CSR_QUAT_Y: quat_in.y = csr_wdata;
            CSR_QUAT_Z: quat_in.z = csr_wdata;
            CSR_QUAT_W: quat_in.w = csr_wdata;
            default:    quat_in = quat_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.x <= QuatXReset;
         quat_ff.y <= QuatYReset;
         quat_ff.z <= QuatZReset;
         quat_ff.w <= QuatWReset;
      end else begin
         quat_ff <= quat_in;
      end
   end

   assign quat = quat_ff;

endmodule

FILE: rtl/pqr_matrix.sv
// Two-stage rotation matrix builder from the quaternion registers.
module pqr_matrix import pqr_pkg::*; (
   input  logic     clock,
   input  quat_type quat,
   output mat_type  mat
);

   // products: wx wy wz xx xy xz yy yz zz
   logic signed [63:0] prod_in [9];
   logic signed [63:0] prod_ff [9];
   logic signed [34:0] dbl [9];
   mat_type            mat_in;
   mat_type            mat_ff;

   always_comb begin
      prod_in[0] = quat.w * quat.x;
      prod_in[1] = quat.w * quat.y;
      prod_in[2] = quat.w * quat.z;
      prod_in[3] = quat.x * quat.x;
      prod_in[4] = quat.x * quat.y;
      prod_in[5] = quat.x * quat.z;
      prod_in[6] = quat.y * quat.y;
      prod_in[7] = quat.y * quat.z;
      prod_in[8] = quat.z * quat.z;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         dbl[i] = rnd_dbl(prod_ff[i]);
      end
      mat_in[0] = sat32(QOne - 36'(dbl[6]) - 36'(dbl[8]));
      mat_in[1] = sat32(36'(dbl[4]) - 36'(dbl[2]));
      mat_in[2] = sat32(36'(dbl[5]) + 36'(dbl[1]));
      mat_in[3] = sat32(36'(dbl[4]) + 36'(dbl[2]));
      mat_in[4] = sat32(QOne - 36'(dbl[3]) - 36'(dbl[8]));
      mat_in[5] = sat32(36'(dbl[7]) - 36'(dbl[0]));
      mat_in[6] = sat32(36'(dbl[5]) - 36'(dbl[1]));
      mat_in[7] = sat32(36'(dbl[7]) + 36'(dbl[0]));
      mat_in[8] = sat32(QOne - 36'(dbl[3]) - 36'(dbl[6]));
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   assign mat = mat_ff;

endmodule

FILE: rtl/pqr_datapath.sv
// Five-stage plane normal rotation pipeline with valid/ready stall control.
module pqr_datapath import pqr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  mat_type mat,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   req_type            s1_ff;
   req_type            s2_ff;
   logic signed [63:0] prod_in [9];
   logic signed [63:0] prod_ff [9];
   logic signed [31:0] off3_ff;
   logic signed [33:0] term_in [9];
   logic signed [33:0] term_ff [9];
   logic signed [31:0] off4_ff;
   rsp_type            rsp_in;
   rsp_type            rsp_ff;
   logic signed [31:0] nvec [3];

   always_comb begin
      adv5 = !v5_ff || rsp_ready;
      adv4 = !v4_ff || adv5;
      adv3 = !v3_ff || adv4;
      adv2 = !v2_ff || adv3;
      adv1 = !v1_ff || adv2;
   end

   // no transaction is taken while reset holds the pipeline empty
   assign req_ready = adv1 && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // row r, column c at index r*3+c
   always_comb begin
      nvec[0] = s2_ff.normal_x;
      nvec[1] = s2_ff.normal_y;
      nvec[2] = s2_ff.normal_z;
      for (int k = 0; k < 9; k++) begin
         prod_in[k] = nvec[k % 3] * $signed(mat[k]);
      end
      for (int k = 0; k < 9; k++) begin
         term_in[k] = rnd_row(prod_ff[k]);
      end
      rsp_in.rotated_x  = sat32(36'(term_ff[0]) + 36'(term_ff[1]) + 36'(term_ff[2]));
      rsp_in.rotated_y  = sat32(36'(term_ff[3]) + 36'(term_ff[4]) + 36'(term_ff[5]));
      rsp_in.rotated_z  = sat32(36'(term_ff[6]) + 36'(term_ff[7]) + 36'(term_ff[8]));
      rsp_in.offset_out = off4_ff;
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         s1_ff <= req_data;
      end
      if (adv2 && v1_ff) begin
         s2_ff <= s1_ff;
      end
      if (adv3 && v2_ff) begin
         prod_ff <= prod_in;
         off3_ff <= s2_ff.offset_d;
      end
      if (adv4 && v3_ff) begin
         term_ff <= term_in;
         off4_ff <= off3_ff;
      end
      if (adv5 && v4_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v5_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/plane_quaternion_rotate_unit.sv
// An accepted transaction passes the s1, s2, product, row term and result registers before its result is valid.
// Throughput: one transaction per cycle; stages stall only behind a held result.
// After a CSR write the matrix is rebuilt from the quaternion registers via the product and matrix registers.
// Reset (synchronous, active high) empties the pipeline and loads the identity quaternion.
module plane_quaternion_rotate_unit import pqr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CsrIdWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]  csr_wdata
);

   quat_type quat;
   mat_type  mat;

   pqr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .quat      (quat)
   );

   pqr_matrix u_matrix (
      .clock (clock),
      .quat  (quat),
      .mat   (mat)
   );

   pqr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .mat       (mat),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/pqr_checker.sv
// Port-level checks for the plane quaternion rotate unit, bound to the top level.
module pqr_checker import pqr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid)
      else $error("result missing four cycles after transaction");

endmodule

bind plane_quaternion_rotate_unit pqr_checker u_pqr_checker (.*);
